// ----- hw/rtl/wsled_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsled_pkg
// Shared types and constants for the WS2812B LED chain driver.
// ----------------------------------------------------------------------------
package wsled_pkg;

   // Chain geometry
   localparam int LED_COUNT = 16;
   localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int PIX_W     = 24;
   localparam int BIT_IDX_W = $clog2(PIX_W);

   localparam logic [LED_IDX_W-1:0] LED_LAST    = LED_IDX_W'(LED_COUNT - 1);
   localparam logic [BIT_IDX_W-1:0] BIT_MSB     = BIT_IDX_W'(PIX_W - 1);
   localparam logic [PIX_W-1:0]     PIX_RESET   = 24'd10;

   // Command codes carried in the mode field
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_BIT_PERIOD   = 2'd0;
   localparam logic [1:0] CSR_ZERO_HIGH    = 2'd1;
   localparam logic [1:0] CSR_ONE_HIGH     = 2'd2;
   localparam logic [1:0] CSR_BREAK_LENGTH = 2'd3;

   // Register reset values
   localparam logic [7:0]  BIT_PERIOD_RESET   = 8'd105;
   localparam logic [7:0]  ZERO_HIGH_RESET    = 8'd33;
   localparam logic [7:0]  ONE_HIGH_RESET     = 8'd67;
   localparam logic [15:0] BREAK_LENGTH_RESET = 16'd25200;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DATA  = 2'd1,
      PH_BREAK = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] pixel_position;
      logic [7:0] green_level;
      logic [7:0] red_level;
      logic [7:0] blue_level;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic data_done;
      logic break_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  bit_period;
      logic [7:0]  zero_high_ticks;
      logic [7:0]  one_high_ticks;
      logic [15:0] break_length;
   } cfg_type;

   typedef struct packed {
      logic                 en;
      logic [LED_IDX_W-1:0] addr;
      logic [PIX_W-1:0]     data;
   } pix_wr_type;

endpackage
`default_nettype wire

// ----- hw/rtl/wsled_pixel_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsled_pixel_store
// GRB colour register file, one write port and one read port with the
// write in the same cycle forwarded to the read.
// ----------------------------------------------------------------------------
module wsled_pixel_store (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire wsled_pkg::pix_wr_type           wr,
   input  wire logic [wsled_pkg::LED_IDX_W-1:0] rd_addr,
   output logic [wsled_pkg::PIX_W-1:0]          rd_data
);

   logic [wsled_pkg::PIX_W-1:0] pixel_ff [wsled_pkg::LED_COUNT];

   // Colour registers, reset to the default colour
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wsled_pkg::LED_COUNT; i++) begin
            pixel_ff[i] <= wsled_pkg::PIX_RESET;
         end
      end else if (wr.en) begin
         pixel_ff[wr.addr] <= wr.data;
      end
   end

   // Read with forwarding of a write in the same cycle
   always_comb begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data = wr.data;
      end else begin
         rd_data = pixel_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/wsled_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsled_sequencer
// Frame state machine: bit position, tick counter, line level and the
// end-of-data / end-of-break pulses, one command per step.
// ----------------------------------------------------------------------------
module wsled_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire wsled_pkg::req_type item,
   input  wire wsled_pkg::cfg_type cfg,
   output wsled_pkg::rsp_type     rsp_in
);

   wsled_pkg::phase_type                phase_ff, phase_in;
   logic [wsled_pkg::LED_IDX_W-1:0]     led_ff, led_in;
   logic [wsled_pkg::BIT_IDX_W-1:0]     bit_ff, bit_in;
   logic [15:0]                         tick_ff, tick_in;
   logic                                data_done;
   logic                                break_done;
   logic [7:0]                          high_ticks;
   logic [wsled_pkg::PIX_W-1:0]         pix_data;
   wsled_pkg::pix_wr_type               pix_wr;

   // Pixel writes go straight to the store, positions off the chain dropped
   always_comb begin
      pix_wr.en   = step && (item.mode == wsled_pkg::MODE_WRITE) &&
                    (32'(item.pixel_position) < wsled_pkg::LED_COUNT);
      pix_wr.addr = wsled_pkg::LED_IDX_W'(item.pixel_position);
      pix_wr.data = {item.green_level, item.red_level, item.blue_level};
   end

   wsled_pixel_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (pix_wr),
      .rd_addr (led_in),
      .rd_data (pix_data)
   );

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsled_pkg::PH_IDLE;
         led_ff   <= '0;
         bit_ff   <= wsled_pkg::BIT_MSB;
         tick_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         led_ff   <= led_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
      end
   end

   // Next state
   always_comb begin
      phase_in   = phase_ff;
      led_in     = led_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      data_done  = 1'b0;
      break_done = 1'b0;
      if (step) begin
         case (item.mode)
            wsled_pkg::MODE_START: begin
               if (phase_ff == wsled_pkg::PH_IDLE) begin
                  phase_in = wsled_pkg::PH_DATA;
                  led_in   = '0;
                  bit_in   = wsled_pkg::BIT_MSB;
                  tick_in  = '0;
               end
            end
            wsled_pkg::MODE_TICK: begin
               case (phase_ff)
                  wsled_pkg::PH_DATA: begin
                     if (tick_ff >= {8'd0, cfg.bit_period}) begin
                        tick_in = '0;
                        if (bit_ff == '0) begin
                           bit_in = wsled_pkg::BIT_MSB;
                           if (led_ff == wsled_pkg::LED_LAST) begin
                              led_in    = '0;
                              phase_in  = wsled_pkg::PH_BREAK;
                              data_done = 1'b1;
                           end else begin
                              led_in = led_ff + wsled_pkg::LED_IDX_W'(1);
                           end
                        end else begin
                           bit_in = bit_ff - wsled_pkg::BIT_IDX_W'(1);
                        end
                     end else begin
                        tick_in = tick_ff + 16'd1;
                     end
                  end
                  wsled_pkg::PH_BREAK: begin
                     if (tick_ff >= cfg.break_length) begin
                        tick_in    = '0;
                        phase_in   = wsled_pkg::PH_IDLE;
                        break_done = 1'b1;
                     end else begin
                        tick_in = tick_ff + 16'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Line level and status after this command
   always_comb begin
      high_ticks        = pix_data[bit_in] ? cfg.one_high_ticks : cfg.zero_high_ticks;
      rsp_in.line_level = (phase_in == wsled_pkg::PH_DATA) && (tick_in < {8'd0, high_ticks});
      rsp_in.busy_res   = (phase_in != wsled_pkg::PH_IDLE);
      rsp_in.data_done  = data_done;
      rsp_in.break_done = break_done;
   end

   // Checks
   a_idle_parked : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsled_pkg::PH_IDLE) |->
         (led_ff == '0) && (bit_ff == wsled_pkg::BIT_MSB) && (tick_ff == '0))
      else $error("idle with a frame position not parked");

   a_data_done_break : assert property (@(posedge clock) disable iff (reset)
      data_done |=> (phase_ff == wsled_pkg::PH_BREAK))
      else $error("end of data without entering the break");

   a_break_done_idle : assert property (@(posedge clock) disable iff (reset)
      break_done |=> (phase_ff == wsled_pkg::PH_IDLE) && !$past(data_done))
      else $error("end of break without going idle");

   a_pulse_on_tick : assert property (@(posedge clock) disable iff (reset)
      (data_done || break_done) |-> (step && (item.mode == wsled_pkg::MODE_TICK)))
      else $error("completion pulse outside a tick");

endmodule
`default_nettype wire

// ----- hw/rtl/ws2812_led_chain_driver.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812_led_chain_driver
// WS2812B chain driver: pixel colour store and serial frame generator.
//
// Commands arrive on the req_ channel (valid/ready): pixel write, frame start
// or one timer tick. Every command gives exactly one status transfer on the
// rsp_ channel: line level, busy, and the end-of-data / end-of-break pulses,
// all showing the state after that command.
// A command is held in an input register, then the frame state machine and
// colour store update in one pass into the result register, which holds the
// response until it is taken. One command per cycle is sustained while the
// receiver takes each result.
// When the receiver stalls, one further command is taken into the input
// register; after that req_ready drops until the result is taken.
// Timing registers are written on the csr_ port and take effect from the
// next command. Synchronous reset clears both stages, sets every LED to the
// default colour, idles the line and loads the default timing.
// ----------------------------------------------------------------------------
module ws2812_led_chain_driver (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire wsled_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output wsled_pkg::rsp_type      rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_write_data
);

   wsled_pkg::cfg_type cfg_ff;
   wsled_pkg::req_type req_ff;
   logic               req_valid_ff;
   logic               rsp_valid_ff;
   wsled_pkg::rsp_type rsp_ff, rsp_in;
   logic               step;

   // Stage movement
   assign step      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period      <= wsled_pkg::BIT_PERIOD_RESET;
         cfg_ff.zero_high_ticks <= wsled_pkg::ZERO_HIGH_RESET;
         cfg_ff.one_high_ticks  <= wsled_pkg::ONE_HIGH_RESET;
         cfg_ff.break_length    <= wsled_pkg::BREAK_LENGTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            wsled_pkg::CSR_BIT_PERIOD:   cfg_ff.bit_period      <= csr_write_data[7:0];
            wsled_pkg::CSR_ZERO_HIGH:    cfg_ff.zero_high_ticks <= csr_write_data[7:0];
            wsled_pkg::CSR_ONE_HIGH:     cfg_ff.one_high_ticks  <= csr_write_data[7:0];
            wsled_pkg::CSR_BREAK_LENGTH: cfg_ff.break_length    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // Frame sequencer
   wsled_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_ff),
      .cfg    (cfg_ff),
      .rsp_in (rsp_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire
